/* rtl/jdc_pkg.sv */
`default_nettype none

package jdc_pkg;

  // field widths
  localparam int JD_W       = 39;
  localparam int FRAC_W     = 16;
  localparam int OUT_FRAC_W = 16;
  localparam int YEAR_W     = 16;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;

  // internal widths, sized from the input range
  localparam int Z_W     = JD_W + 1 - FRAC_W;  // day number after the half-day shift
  localparam int ALPHA_W = 8;                  // gregorian century correction
  localparam int B_W     = 24;                 // shifted day count
  localparam int C_W     = 15;                 // year count from the epoch
  localparam int X_W     = 9;                  // day within the march-based year
  localparam int E_W     = 4;                  // march-based month index

  // first day of the gregorian calendar
  localparam logic [Z_W-1:0] GREG_START = Z_W'(2299161);

  // alpha = floor((4z - 7468865) / 146097)
  localparam int N1_W = Z_W + 1;
  localparam logic [N1_W:0]     ALPHA_OFS = (N1_W + 1)'(7468865);
  localparam logic [N1_W-1:0]   D1        = N1_W'(146097);
  localparam logic [ALPHA_W-1:0] M1       = ALPHA_W'((64'd1 << N1_W) / 64'd146097);

  // b = a + 1524
  localparam logic [B_W-1:0] B_OFS = B_W'(1524);

  // c = floor((20b - 2442) / 7305)
  localparam int N2_W  = B_W + 4;
  localparam int QE2_W = 16;
  localparam logic [N2_W:0]     C_MUL = (N2_W + 1)'(20);
  localparam logic [N2_W:0]     C_OFS = (N2_W + 1)'(2442);
  localparam logic [N2_W-1:0]   D2    = N2_W'(7305);
  localparam logic [QE2_W-1:0]  M2    = QE2_W'((64'd1 << N2_W) / 64'd7305);

  // d = floor(1461c / 4)
  localparam int DP_W = C_W + 11;
  localparam logic [DP_W-1:0] D_MUL = DP_W'(1461);

  // e = floor(10000x / 306001)
  localparam int N3_W  = X_W + 14;
  localparam int QE3_W = E_W + 1;
  localparam logic [N3_W-1:0]  E_MUL = N3_W'(10000);
  localparam logic [N3_W-1:0]  D3    = N3_W'(306001);
  localparam logic [QE3_W-1:0] M3    = QE3_W'((64'd1 << N3_W) / 64'd306001);

  // month and year mapping
  localparam logic [E_W-1:0]     E_WRAP      = E_W'(14);
  localparam logic [E_W-1:0]     E_SUB_LOW   = E_W'(1);
  localparam logic [E_W-1:0]     E_SUB_HIGH  = E_W'(13);
  localparam logic [MONTH_W-1:0] FEBRUARY    = MONTH_W'(2);
  localparam logic [YEAR_W:0]    YEAR_OFS_MF = (YEAR_W + 1)'(4716);
  localparam logic [YEAR_W:0]    YEAR_OFS_JF = (YEAR_W + 1)'(4715);

  // stage hand-over between the sub-blocks
  typedef struct packed {
    logic              valid;
    logic [B_W-1:0]    b;
    logic [FRAC_W-1:0] f;
  } jdc_day_t;

  typedef struct packed {
    logic              valid;
    logic [C_W-1:0]    c;
    logic [X_W-1:0]    x;
    logic [FRAC_W-1:0] f;
  } jdc_cyc_t;

  // floor(306001 * e / 10000): days before the start of month index e
  function automatic logic [X_W-1:0] month_start(input logic [E_W-1:0] e);
    logic [X_W-1:0] v;
    case (e)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      4'd15:   v = 9'd459;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // rescale the day fraction to the output precision (truncate or pad with zeros)
  function automatic logic [OUT_FRAC_W-1:0] frac_out(input logic [FRAC_W-1:0] f);
    logic [FRAC_W+OUT_FRAC_W-1:0] w;
    w = {f, {OUT_FRAC_W{1'b0}}};
    return w[FRAC_W+OUT_FRAC_W-1 -: OUT_FRAC_W];
  endfunction

endpackage

`default_nettype wire

/* rtl/jdc_alpha.sv */
`default_nettype none

module jdc_alpha (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [jdc_pkg::JD_W-1:0]    in_julian_date,
  output jdc_pkg::jdc_day_t                out_day
);
  import jdc_pkg::*;

  // stage 1: add half a day, split day number and fraction
  logic [JD_W:0]      sum_w;
  logic               v1_r;
  logic [Z_W-1:0]     z1_r, z1_nxt;
  logic [FRAC_W-1:0]  f1_r, f1_nxt;

  always_comb begin
    sum_w  = {1'b0, in_julian_date} + ((JD_W + 1)'(1) << (FRAC_W - 1));
    z1_nxt = sum_w[JD_W:FRAC_W];
    f1_nxt = sum_w[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= z1_nxt;
    f1_r <= f1_nxt;
  end

  // stage 2: calendar select and numerator of the century correction
  logic [N1_W:0]      n1_full;
  logic               v2_r;
  logic               greg2_r, greg2_nxt;
  logic [N1_W-1:0]    n1_2_r, n1_2_nxt;
  logic [Z_W-1:0]     z2_r;
  logic [FRAC_W-1:0]  f2_r;

  always_comb begin
    greg2_nxt = (z1_r >= GREG_START);
    n1_full   = {z1_r, 2'b00} - ALPHA_OFS;
    n1_2_nxt  = greg2_nxt ? n1_full[N1_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    greg2_r <= greg2_nxt;
    n1_2_r  <= n1_2_nxt;
    z2_r    <= z1_r;
    f2_r    <= f1_r;
  end

  // stage 3: reciprocal estimate of alpha, low by at most one
  logic [N1_W+ALPHA_W-1:0] mul1;
  logic                    v3_r;
  logic [ALPHA_W-1:0]      qe3_r, qe3_nxt;
  logic [N1_W-1:0]         n1_3_r;
  logic                    greg3_r;
  logic [Z_W-1:0]          z3_r;
  logic [FRAC_W-1:0]       f3_r;

  always_comb begin
    mul1    = (N1_W + ALPHA_W)'(n1_2_r) * (N1_W + ALPHA_W)'(M1);
    qe3_nxt = mul1[N1_W +: ALPHA_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    qe3_r   <= qe3_nxt;
    n1_3_r  <= n1_2_r;
    greg3_r <= greg2_r;
    z3_r    <= z2_r;
    f3_r    <= f2_r;
  end

  // stage 4: remainder check corrects the estimate
  logic [N1_W-1:0]    r1;
  logic               v4_r;
  logic [ALPHA_W-1:0] alpha4_r, alpha4_nxt;
  logic               greg4_r;
  logic [Z_W-1:0]     z4_r;
  logic [FRAC_W-1:0]  f4_r;

  always_comb begin
    r1         = n1_3_r - N1_W'(qe3_r) * D1;
    alpha4_nxt = qe3_r + ALPHA_W'(r1 >= D1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    alpha4_r <= alpha4_nxt;
    greg4_r  <= greg3_r;
    z4_r     <= z3_r;
    f4_r     <= f3_r;
  end

  // stage 5: b = z + correction + 1524
  logic [ALPHA_W-1:0] adj;
  logic               v5_r;
  logic [B_W-1:0]     b5_r, b5_nxt;
  logic [FRAC_W-1:0]  f5_r;

  always_comb begin
    adj    = greg4_r ? (ALPHA_W'(1) + alpha4_r - (alpha4_r >> 2)) : '0;
    b5_nxt = B_W'(z4_r) + B_W'(adj) + B_OFS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    b5_r <= b5_nxt;
    f5_r <= f4_r;
  end

  assign out_day = '{valid: v5_r, b: b5_r, f: f5_r};

endmodule

`default_nettype wire

/* rtl/jdc_century.sv */
`default_nettype none

module jdc_century (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jdc_pkg::jdc_day_t  in_day,
  output jdc_pkg::jdc_cyc_t       out_cyc
);
  import jdc_pkg::*;

  // stage 6: numerator 20b - 2442
  logic [N2_W:0]     n2_full;
  logic              v6_r;
  logic [N2_W-1:0]   n2_6_r, n2_6_nxt;
  logic [B_W-1:0]    b6_r;
  logic [FRAC_W-1:0] f6_r;

  always_comb begin
    n2_full  = (N2_W + 1)'(in_day.b) * C_MUL - C_OFS;
    n2_6_nxt = n2_full[N2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= in_day.valid;
    end
  end

  always_ff @(posedge clk) begin
    n2_6_r <= n2_6_nxt;
    b6_r   <= in_day.b;
    f6_r   <= in_day.f;
  end

  // stage 7: reciprocal estimate of c
  logic [N2_W+QE2_W-1:0] mul2;
  logic                  v7_r;
  logic [QE2_W-1:0]      qe7_r, qe7_nxt;
  logic [N2_W-1:0]       n2_7_r;
  logic [B_W-1:0]        b7_r;
  logic [FRAC_W-1:0]     f7_r;

  always_comb begin
    mul2    = (N2_W + QE2_W)'(n2_6_r) * (N2_W + QE2_W)'(M2);
    qe7_nxt = mul2[N2_W +: QE2_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    qe7_r  <= qe7_nxt;
    n2_7_r <= n2_6_r;
    b7_r   <= b6_r;
    f7_r   <= f6_r;
  end

  // stage 8: remainder check corrects c
  logic [N2_W-1:0]   r2;
  logic [QE2_W-1:0]  c_full;
  logic              v8_r;
  logic [C_W-1:0]    c8_r, c8_nxt;
  logic [B_W-1:0]    b8_r;
  logic [FRAC_W-1:0] f8_r;

  always_comb begin
    r2     = n2_7_r - N2_W'(qe7_r) * D2;
    c_full = qe7_r + QE2_W'(r2 >= D2);
    c8_nxt = c_full[C_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    c8_r <= c8_nxt;
    b8_r <= b7_r;
    f8_r <= f7_r;
  end

  // stage 9: d = floor(1461c / 4), day within the year x = b - d
  logic [DP_W-1:0]   dprod;
  logic [B_W-1:0]    d9;
  logic [B_W-1:0]    x_full;
  logic              v9_r;
  logic [X_W-1:0]    x9_r, x9_nxt;
  logic [C_W-1:0]    c9_r;
  logic [FRAC_W-1:0] f9_r;

  always_comb begin
    dprod  = DP_W'(c8_r) * D_MUL;
    d9     = dprod[DP_W-1:2];
    x_full = b8_r - d9;
    x9_nxt = x_full[X_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    x9_r <= x9_nxt;
    c9_r <= c8_r;
    f9_r <= f8_r;
  end

  assign out_cyc = '{valid: v9_r, c: c9_r, x: x9_r, f: f9_r};

endmodule

`default_nettype wire

/* rtl/jdc_month.sv */
`default_nettype none

module jdc_month (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire jdc_pkg::jdc_cyc_t             in_cyc,
  output logic                               out_valid,
  output logic signed [jdc_pkg::YEAR_W-1:0]  out_year,
  output logic [jdc_pkg::MONTH_W-1:0]        out_month,
  output logic [jdc_pkg::DAY_W-1:0]          out_day_of_month,
  output logic [jdc_pkg::OUT_FRAC_W-1:0]     out_day_fraction
);
  import jdc_pkg::*;

  // stage 10: numerator 10000x
  logic              v10_r;
  logic [N3_W-1:0]   n3_10_r, n3_10_nxt;
  logic [X_W-1:0]    x10_r;
  logic [C_W-1:0]    c10_r;
  logic [FRAC_W-1:0] f10_r;

  assign n3_10_nxt = N3_W'(in_cyc.x) * E_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= in_cyc.valid;
    end
  end

  always_ff @(posedge clk) begin
    n3_10_r <= n3_10_nxt;
    x10_r   <= in_cyc.x;
    c10_r   <= in_cyc.c;
    f10_r   <= in_cyc.f;
  end

  // stage 11: reciprocal estimate of the month index
  logic [N3_W+QE3_W-1:0] mul3;
  logic                  v11_r;
  logic [QE3_W-1:0]      qe11_r, qe11_nxt;
  logic [N3_W-1:0]       n3_11_r;
  logic [X_W-1:0]        x11_r;
  logic [C_W-1:0]        c11_r;
  logic [FRAC_W-1:0]     f11_r;

  always_comb begin
    mul3     = (N3_W + QE3_W)'(n3_10_r) * (N3_W + QE3_W)'(M3);
    qe11_nxt = mul3[N3_W +: QE3_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else begin
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    qe11_r  <= qe11_nxt;
    n3_11_r <= n3_10_r;
    x11_r   <= x10_r;
    c11_r   <= c10_r;
    f11_r   <= f10_r;
  end

  // stage 12: remainder check corrects e
  logic [N3_W-1:0]   r3;
  logic [QE3_W-1:0]  e_full;
  logic              v12_r;
  logic [E_W-1:0]    e12_r, e12_nxt;
  logic [X_W-1:0]    x12_r;
  logic [C_W-1:0]    c12_r;
  logic [FRAC_W-1:0] f12_r;

  always_comb begin
    r3      = n3_11_r - N3_W'(qe11_r) * D3;
    e_full  = qe11_r + QE3_W'(r3 >= D3);
    e12_nxt = e_full[E_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else begin
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    e12_r <= e12_nxt;
    x12_r <= x11_r;
    c12_r <= c11_r;
    f12_r <= f11_r;
  end

  // stage 13: day, month and year into the output registers
  logic [X_W-1:0]            day_full;
  logic [E_W-1:0]            mon_idx;
  logic [YEAR_W:0]           year_full;
  logic                      valid_r;
  logic [YEAR_W-1:0]         year_r, year_nxt;
  logic [MONTH_W-1:0]        month_r, month_nxt;
  logic [DAY_W-1:0]          day_r, day_nxt;
  logic [OUT_FRAC_W-1:0]     frac_r, frac_nxt;

  always_comb begin
    day_full  = x12_r - month_start(e12_r);
    day_nxt   = day_full[DAY_W-1:0];
    mon_idx   = (e12_r < E_WRAP) ? (e12_r - E_SUB_LOW) : (e12_r - E_SUB_HIGH);
    month_nxt = MONTH_W'(mon_idx);
    // january and february belong to the following year
    year_full = (YEAR_W + 1)'(c12_r) - ((month_nxt > FEBRUARY) ? YEAR_OFS_MF : YEAR_OFS_JF);
    year_nxt  = year_full[YEAR_W-1:0];
    frac_nxt  = frac_out(f12_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    frac_r  <= frac_nxt;
  end

  assign out_valid        = valid_r;
  assign out_year         = signed'(year_r);
  assign out_month        = month_r;
  assign out_day_of_month = day_r;
  assign out_day_fraction = frac_r;

endmodule

`default_nettype wire

/* rtl/julian_day_to_calendar.sv */
// Julian Date to calendar date converter.
//
// Input: in_julian_date is a Julian Date in unsigned fixed point with 16
// fraction bits. An item is taken at each rising edge where start is high
// and busy is low. busy stays low: the block takes a new item in every cycle.
//
// Output: out_valid is high for exactly one cycle per item, with out_year
// (astronomical, two's complement), out_month, out_day_of_month and
// out_day_fraction valid in that same cycle. Results leave in the order the
// items came in.
//
// Throughput is one item per cycle. The depth is set by the three divisions
// by constants (reciprocal multiply, then remainder correction), each taking
// two stages, plus the adds and the final date mapping.
//
// A synchronous reset (rst_n low) clears all valid bits, so items in flight
// are dropped and no result appears until new items pass through. The
// receiver cannot stall the block, so there is no back-pressure path.
`default_nettype none

module julian_day_to_calendar (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [jdc_pkg::JD_W-1:0]      in_julian_date,
  output logic                               out_valid,
  output logic signed [jdc_pkg::YEAR_W-1:0]  out_year,
  output logic [jdc_pkg::MONTH_W-1:0]        out_month,
  output logic [jdc_pkg::DAY_W-1:0]          out_day_of_month,
  output logic [jdc_pkg::OUT_FRAC_W-1:0]     out_day_fraction
);
  import jdc_pkg::*;

  logic     in_valid;
  jdc_day_t day_s;
  jdc_cyc_t cyc_s;

  // fully pipelined: never refuses an item
  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  // day split and gregorian correction
  jdc_alpha u_alpha (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_julian_date (in_julian_date),
    .out_day        (day_s)
  );

  // year count and day within the year
  jdc_century u_century (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_day  (day_s),
    .out_cyc (cyc_s)
  );

  // month, day of month and year
  jdc_month u_month (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cyc           (cyc_s),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_day_fraction (out_day_fraction)
  );

endmodule

`default_nettype wire

/* rtl/jdc_checker.sv */
`default_nettype none

module jdc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [jdc_pkg::JD_W-1:0]      in_julian_date,
  input wire logic                          out_valid,
  input wire logic [jdc_pkg::MONTH_W-1:0]   out_month,
  input wire logic [jdc_pkg::DAY_W-1:0]     out_day_of_month,
  input wire logic [jdc_pkg::OUT_FRAC_W-1:0] out_day_fraction
);
  import jdc_pkg::*;

  localparam int LATENCY = 13;

  // every accepted item yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item produced no result");

  // no result without an item accepted the latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without a matching item");

  // the day fraction is the input fraction shifted by half a day
  a_fraction: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY
      (out_day_fraction == ($past(in_julian_date[15:0], LATENCY) + 16'h8000)))
    else $error("day fraction misaligned with its item");

  // a result always carries a real month and a non-zero day
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= MONTH_W'(1) && out_month <= MONTH_W'(12) &&
                   out_day_of_month != '0))
    else $error("month or day out of range");

endmodule

bind julian_day_to_calendar jdc_checker u_jdc_checker (.*);

`default_nettype wire
